// ----- hw/rtl/bsrg_pkg.sv -----
// Shared types, widths and helper functions for the BCube source-route generator.
// Used by the controller, the datapath and the top level; depends on nothing.
package bsrg_pkg;

  localparam int MAX_LEVELS = 4;
  localparam int MAX_PORTS  = 8;

  localparam int HOST_W  = 12;
  localparam int NODE_W  = 13;
  localparam int LVL_W   = 2;
  localparam int PORT_W  = 4;
  localparam int DIGIT_W = 3;
  localparam int PIDX_W  = 3;
  localparam int PROD_W  = NODE_W + DIGIT_W;
  localparam int WIDX_W  = 1;

  localparam logic [WIDX_W-1:0] REG_LEVELS = 1'd0;
  localparam logic [WIDX_W-1:0] REG_PORTS  = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POW,
    ST_CHECK,
    ST_DIGIT,
    ST_SWITCH,
    ST_HOST
  } state_t;

  typedef struct packed {
    logic load;
    logic pow_step;
    logic check;
    logic digit;
    logic sw;
    logic host;
    logic step_level;
  } cmd_t;

  typedef struct packed {
    logic pow_last;
    logic route_ok;
    logic differ;
    logic low_eq;
    logic level_zero;
  } sts_t;

  // Highest usable level, limited to what the storage holds.
  function automatic logic [LVL_W-1:0] eff_levels(input logic [LVL_W-1:0] lv);
    logic [LVL_W-1:0] k;
    k = lv;
    if (int'(lv) > MAX_LEVELS - 1) k = LVL_W'(MAX_LEVELS - 1);
    return k;
  endfunction

  // Digit base clamped into the supported range.
  function automatic logic [PORT_W-1:0] eff_ports(input logic [PORT_W-1:0] p);
    logic [PORT_W-1:0] n;
    n = p;
    if (p < PORT_W'(2)) n = PORT_W'(2);
    if (p > PORT_W'(MAX_PORTS)) n = PORT_W'(MAX_PORTS);
    return n;
  endfunction

  // Leading digit of rem with place value pw, for rem below base times pw.
  function automatic logic [DIGIT_W-1:0] lead_digit(input logic [NODE_W-1:0] rem,
                                                    input logic [NODE_W-1:0] pw);
    logic [DIGIT_W-1:0] d;
    logic [PROD_W-1:0]  m;
    d = '0;
    for (int i = 1; i < MAX_PORTS; i++) begin
      m = PROD_W'(pw) * PROD_W'(i);
      if (m <= PROD_W'(rem)) d = DIGIT_W'(i);
    end
    return d;
  endfunction

endpackage

// ----- hw/rtl/bsrg_ctrl.sv -----
// Sequencing state machine of the BCube source-route generator.
// Depends on bsrg_pkg for the state type and the command and status structs.
module bsrg_ctrl import bsrg_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  sts_t   sts,
  output cmd_t   cmd,
  output logic   busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_POW;
      end
      ST_POW: begin
        if (sts.pow_last) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = sts.route_ok ? ST_DIGIT : ST_IDLE;
      end
      ST_DIGIT: begin
        state_next = ST_SWITCH;
      end
      ST_SWITCH: begin
        if (sts.differ) state_next = ST_HOST;
        else if (sts.level_zero) state_next = ST_IDLE;
        else state_next = ST_DIGIT;
      end
      ST_HOST: begin
        if (sts.low_eq || sts.level_zero) state_next = ST_IDLE;
        else state_next = ST_DIGIT;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_POW:    cmd.pow_step = 1'b1;
      ST_CHECK:  cmd.check = 1'b1;
      ST_DIGIT:  cmd.digit = 1'b1;
      ST_SWITCH: begin
        cmd.sw         = 1'b1;
        cmd.step_level = !sts.differ;
      end
      ST_HOST: begin
        cmd.host       = 1'b1;
        cmd.step_level = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

// ----- hw/rtl/bsrg_datapath.sv -----
// Datapath of the BCube source-route generator: configuration registers, power
// table, digit extraction, route arithmetic and result registers. Uses bsrg_pkg.
module bsrg_datapath import bsrg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [WIDX_W-1:0]   wr_index,
  input  logic [PORT_W-1:0]   wr_data,
  input  logic [HOST_W-1:0]   src_host,
  input  logic [HOST_W-1:0]   dest_host,
  input  cmd_t                cmd,
  output sts_t                sts,
  output logic                result_valid,
  output logic [NODE_W-1:0]   node_id,
  output logic                is_switch,
  output logic                blocked,
  output logic                last
);

  logic [LVL_W-1:0]   levels;
  logic [PORT_W-1:0]  ports;

  logic [LVL_W-1:0]   k;
  logic [PORT_W-1:0]  n;
  logic [NODE_W-1:0]  pw [MAX_LEVELS+1];
  logic [PIDX_W-1:0]  pidx;
  logic [LVL_W-1:0]   lvl;
  logic [HOST_W-1:0]  src;
  logic [HOST_W-1:0]  dst;
  logic [NODE_W-1:0]  src_rem;
  logic [NODE_W-1:0]  dst_rem;
  logic [HOST_W-1:0]  dst_hi;
  logic [HOST_W-1:0]  cur;
  logic [DIGIT_W-1:0] ds;
  logic [DIGIT_W-1:0] dd;
  logic [NODE_W-1:0]  ds_pw;
  logic [NODE_W-1:0]  dd_pw;
  logic [NODE_W-1:0]  swbase;
  logic               low_eq;

  logic [NODE_W-1:0]  hosts;
  logic [NODE_W-1:0]  pw_lvl;
  logic [NODE_W-1:0]  pw_prev;
  logic [NODE_W-1:0]  src_low;
  logic [NODE_W-1:0]  dst_low;
  logic [NODE_W-1:0]  rest;
  logic               bad;
  logic [DIGIT_W-1:0] ds_new;
  logic [DIGIT_W-1:0] dd_new;

  assign hosts   = pw[PIDX_W'(k) + PIDX_W'(1)];
  assign pw_lvl  = pw[PIDX_W'(lvl)];
  assign pw_prev = pw[pidx - PIDX_W'(1)];
  assign src_low = src_rem - ds_pw;
  assign dst_low = dst_rem - dd_pw;
  assign rest    = NODE_W'(NODE_W'(dst_hi) * pw_lvl) + src_low;
  assign bad     = (NODE_W'(src) >= hosts) || (NODE_W'(dst) >= hosts) || (src == dst);
  assign ds_new  = lead_digit(src_rem, pw_lvl);
  assign dd_new  = lead_digit(dst_rem, pw_lvl);

  assign sts.pow_last   = (pidx == PIDX_W'(k) + PIDX_W'(1));
  assign sts.route_ok   = !bad;
  assign sts.differ     = (ds != dd);
  assign sts.low_eq     = low_eq;
  assign sts.level_zero = (lvl == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= LVL_W'(1);
      ports  <= PORT_W'(4);
    end else if (wr_en) begin
      if (wr_index == REG_LEVELS) levels <= wr_data[LVL_W-1:0];
      if (wr_index == REG_PORTS)  ports  <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.check || cmd.host || (cmd.sw && (ds != dd)));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k       <= eff_levels(levels);
      n       <= eff_ports(ports);
      lvl     <= eff_levels(levels);
      pw[0]   <= NODE_W'(1);
      pidx    <= PIDX_W'(1);
      src     <= src_host;
      dst     <= dest_host;
      src_rem <= NODE_W'(src_host);
      dst_rem <= NODE_W'(dest_host);
      cur     <= src_host;
      dst_hi  <= '0;
    end
    if (cmd.pow_step) begin
      pw[pidx] <= NODE_W'(pw_prev * NODE_W'(n));
      pidx     <= pidx + PIDX_W'(1);
    end
    if (cmd.check) begin
      node_id   <= bad ? '0 : NODE_W'(src);
      is_switch <= 1'b0;
      blocked   <= bad;
      last      <= bad;
    end
    if (cmd.digit) begin
      ds     <= ds_new;
      dd     <= dd_new;
      ds_pw  <= NODE_W'(PROD_W'(pw_lvl) * PROD_W'(ds_new));
      dd_pw  <= NODE_W'(PROD_W'(pw_lvl) * PROD_W'(dd_new));
      swbase <= hosts + NODE_W'(NODE_W'(lvl) * pw[PIDX_W'(k)]);
    end
    if (cmd.sw) begin
      src_rem   <= src_low;
      dst_rem   <= dst_low;
      dst_hi    <= HOST_W'(dst_hi * HOST_W'(n)) + HOST_W'(dd);
      low_eq    <= (src_low == dst_low);
      node_id   <= swbase + rest;
      is_switch <= 1'b1;
      blocked   <= 1'b0;
      last      <= 1'b0;
    end
    if (cmd.host) begin
      cur       <= HOST_W'(NODE_W'(cur) - ds_pw + dd_pw);
      node_id   <= NODE_W'(cur) - ds_pw + dd_pw;
      is_switch <= 1'b0;
      blocked   <= 1'b0;
      last      <= low_eq;
    end
    if (cmd.step_level) begin
      lvl <= lvl - LVL_W'(1);
    end
  end

endmodule

// ----- hw/rtl/bcube_source_route_generator_unit.sv -----
// Top level of the BCube source-route generator.
// Joins bsrg_ctrl and bsrg_datapath; types and widths come from bsrg_pkg.
//
// Usage. A route request is taken at a rising edge with start high and busy
// low: src_host and dest_host are sampled there. The block then emits the
// route one item at a time on node_id, is_switch, blocked and last, each item
// shown for exactly one cycle with result_valid high. The first item is the
// source host; for every differing digit, from the top level down, a switch
// item and then the corrected host item follow. The final item has last set.
// A host outside the network, or equal hosts, gives one item with blocked and
// last set and node_id zero.
//
// Sequence. After acceptance the power table is built up to entry k+1, one
// multiply per cycle (k the configured highest level), then a check step
// tests the range and emits the source. Each level then runs a digit split
// and a switch step when its digits match, and adds a host step when they
// differ, until the lower digits agree. busy falls in the cycle the last
// item is shown, and one route runs at a time.
//
// Configuration is written through wr_en, wr_index and wr_data while busy is
// low. Reset restores levels to 1 and ports to 4 and returns to idle. The
// receiver must take each item in the cycle it is shown; there is no stall.
module bcube_source_route_generator_unit import bsrg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                wr_en,
  input  logic [WIDX_W-1:0]   wr_index,
  input  logic [PORT_W-1:0]   wr_data,
  input  logic [HOST_W-1:0]   src_host,
  input  logic [HOST_W-1:0]   dest_host,
  output logic                result_valid,
  output logic [NODE_W-1:0]   node_id,
  output logic                is_switch,
  output logic                blocked,
  output logic                last
);

  cmd_t cmd;
  sts_t sts;

  // The controller only sequences; all arithmetic lives in the datapath.
  bsrg_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bsrg_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .src_host     (src_host),
    .dest_host    (dest_host),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .node_id      (node_id),
    .is_switch    (is_switch),
    .blocked      (blocked),
    .last         (last)
  );

endmodule
